### sv/nfba_pkg.sv
// Shared types and constants for the next-free block allocator.
package nfba_pkg;

  localparam int NUM_BLOCKS_DEF = 128;
  localparam int MAX_FILES_DEF  = 255;

  localparam logic [7:0] MARK_OWNER = 8'd1;

  localparam logic MODE_MARK  = 1'b0;
  localparam logic MODE_ALLOC = 1'b1;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_PARTIAL  = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NO_FILES = 2'd3;

  typedef struct packed {
    logic       mode;
    logic [7:0] block_index;
    logic [5:0] block_count;
  } in_item_t;

  typedef struct packed {
    logic       block_valid;
    logic [6:0] claimed_block;
    logic [7:0] file_number;
    logic [1:0] status;
    logic [5:0] claimed_count;
    logic       last;
  } out_item_t;

endpackage

### sv/next_free_block_allocator.sv
// Next-free block allocator: ownership map, scan sequencer and result register.
//
// After reset the block runs a clearing pass over the ownership map, one entry
// per cycle, holding busy high until every entry is cleared. A mark beat completes in
// the accepting cycle: busy stays low and its single result appears on the next
// cycle. An allocate beat (or one rejected for lack of file numbers, which is
// answered at once like a mark) holds busy high while the map is scanned one
// block per cycle through a single read port with registered data, and through
// the summary state that follows the scan. Each
// result is shown for exactly one cycle with out_valid high, and the receiver
// must take it then, since the block cannot be stalled.
module next_free_block_allocator #(
  parameter int NUM_BLOCKS = nfba_pkg::NUM_BLOCKS_DEF,
  parameter int MAX_FILES  = nfba_pkg::MAX_FILES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  nfba_pkg::in_item_t  in_item,
  output logic                out_valid,
  output nfba_pkg::out_item_t out_item
);
  import nfba_pkg::*;

  localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int KW = (AW + 1 > 8) ? AW + 1 : 8;
  localparam logic [KW-1:0] LAST_K = KW'(NUM_BLOCKS);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_SUMMARY} state_t;

  state_t        state_r, state_nxt;
  logic [KW-1:0] scan_k_r, scan_k_nxt;
  logic [KW-1:0] chk_k_r, chk_k_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic [5:0]    got_r, got_nxt;
  logic [5:0]    want_r, want_nxt;
  logic [7:0]    fnum_r, fnum_nxt;
  logic [7:0]    file_cnt_r, file_cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_item_r, out_item_nxt;

  logic [7:0]    owner_mem [NUM_BLOCKS];
  logic [7:0]    rd_data_r;
  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  always_comb begin
    state_nxt     = state_r;
    scan_k_nxt    = scan_k_r;
    chk_k_nxt     = chk_k_r;
    chk_vld_nxt   = 1'b0;
    got_nxt       = got_r;
    want_nxt      = want_r;
    fnum_nxt      = fnum_r;
    file_cnt_nxt  = file_cnt_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = scan_k_r[AW-1:0];
    wr_data       = '0;

    case (state_r)
      S_CLEAR: begin
        wr_en      = 1'b1;
        scan_k_nxt = scan_k_r + 1'b1;
        if (scan_k_r == LAST_K - 1'b1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (in_item.mode == MODE_MARK) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{block_valid: 1'b0, claimed_block: '0,
                              file_number: MARK_OWNER, status: ST_DONE,
                              claimed_count: '0, last: 1'b1};
            if (KW'(in_item.block_index) < LAST_K) begin
              wr_en   = 1'b1;
              wr_addr = AW'(in_item.block_index);
              wr_data = MARK_OWNER;
            end else begin
              out_item_nxt.status = ST_RANGE;
            end
          end else if (file_cnt_r >= 8'(MAX_FILES)) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{block_valid: 1'b0, claimed_block: '0,
                              file_number: '0, status: ST_NO_FILES,
                              claimed_count: '0, last: 1'b1};
          end else begin
            file_cnt_nxt = file_cnt_r + 1'b1;
            fnum_nxt     = file_cnt_r + 1'b1;
            scan_k_nxt   = KW'(in_item.block_index);
            want_nxt     = in_item.block_count;
            got_nxt      = '0;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Reads run one block ahead of the free check; an extra read past the
        // end of the request is simply dropped.
        if (scan_k_r < LAST_K) begin
          rd_en       = 1'b1;
          chk_vld_nxt = 1'b1;
          chk_k_nxt   = scan_k_r;
          scan_k_nxt  = scan_k_r + 1'b1;
        end
        if (chk_vld_r && rd_data_r == 8'd0 && got_r != want_r) begin
          wr_en         = 1'b1;
          wr_addr       = chk_k_r[AW-1:0];
          wr_data       = fnum_r;
          got_nxt       = got_r + 1'b1;
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{block_valid: 1'b1, claimed_block: chk_k_r[6:0],
                            file_number: fnum_r, status: ST_DONE,
                            claimed_count: got_r + 1'b1, last: 1'b0};
        end
        if (got_nxt == want_r || scan_k_r >= LAST_K) begin
          state_nxt = S_SUMMARY;
        end
      end
      S_SUMMARY: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{block_valid: 1'b0, claimed_block: '0,
                          file_number: fnum_r,
                          status: (got_r == want_r) ? ST_DONE : ST_PARTIAL,
                          claimed_count: got_r, last: 1'b1};
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      scan_k_r    <= '0;
      chk_vld_r   <= 1'b0;
      file_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      out_item_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      scan_k_r    <= scan_k_nxt;
      chk_vld_r   <= chk_vld_nxt;
      file_cnt_r  <= file_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      out_item_r  <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_k_r    <= chk_k_nxt;
    got_r      <= got_nxt;
    want_r     <= want_nxt;
    fnum_r     <= fnum_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      owner_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= owner_mem[scan_k_r[AW-1:0]];
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### test/next_free_block_allocator_test.sv
// Self-checking testbench for the next-free block allocator with a built-in map predictor.
module next_free_block_allocator_test;
  import nfba_pkg::*;

  localparam int NUM_BLOCKS = NUM_BLOCKS_DEF;
  localparam int MAX_FILES = MAX_FILES_DEF;
  localparam int IDLE_LIMIT = 4 * (NUM_BLOCKS + 2) + 1000;
  localparam int SETTLE_CYCLES = NUM_BLOCKS + 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;

  in_item_t alloc_requests[$];
  out_item_t expected_grants[$];

  logic [7:0] owner_map[NUM_BLOCKS];
  logic [7:0] file_ctr;

  int sender_idle_pct = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int beats_in = 0;
  int results_checked = 0;
  int blocks_granted = 0;
  int refused_requests = 0;

  next_free_block_allocator #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .MAX_FILES(MAX_FILES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Updates the predicted map and queues every result the beat will produce.
  task automatic apply_request(input in_item_t beat);
    out_item_t r;
    int blk;
    int got;
    logic [7:0] fnum;
    r = '0;
    r.last = 1'b1;
    if (beat.mode == MODE_MARK) begin
      r.file_number = MARK_OWNER;
      if (beat.block_index < NUM_BLOCKS) begin
        owner_map[beat.block_index] = MARK_OWNER;
        r.status = ST_DONE;
      end else begin
        r.status = ST_RANGE;
      end
      expected_grants.push_back(r);
    end else if (file_ctr >= MAX_FILES) begin
      r.status = ST_NO_FILES;
      refused_requests++;
      expected_grants.push_back(r);
    end else begin
      file_ctr = file_ctr + 8'd1;
      fnum = file_ctr;
      got = 0;
      for (blk = beat.block_index; blk < NUM_BLOCKS && got < beat.block_count; blk++) begin
        if (owner_map[blk] == 8'd0) begin
          owner_map[blk] = fnum;
          got++;
          r = '0;
          r.block_valid = 1'b1;
          r.claimed_block = blk[6:0];
          r.file_number = fnum;
          r.claimed_count = got[5:0];
          expected_grants.push_back(r);
        end
      end
      r = '0;
      r.file_number = fnum;
      r.status = (got == beat.block_count) ? ST_DONE : ST_PARTIAL;
      r.claimed_count = got[5:0];
      r.last = 1'b1;
      expected_grants.push_back(r);
    end
  endtask

  task automatic note_mismatch(input string field, input int want, input int got);
    if (mismatches < 10) begin
      $display("mismatch on %s: expected %0d, got %0d (result %0d)", field, want, got,
               results_checked);
    end
    mismatches++;
  endtask

  // Driver: a new beat may go out whenever start is low or the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_item <= '0;
    end else begin
      if (start && !busy) begin
        apply_request(in_item);
        beats_in++;
      end
      if (!start || !busy) begin
        if (alloc_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          start <= 1'b1;
          in_item <= alloc_requests.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobed result is matched against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_grants.size() == 0) begin
        note_mismatch("unexpected result, block_valid", -1, out_item.block_valid);
      end else begin
        want = expected_grants.pop_front();
        if (want.block_valid != out_item.block_valid)
          note_mismatch("block_valid", want.block_valid, out_item.block_valid);
        if (want.claimed_block != out_item.claimed_block)
          note_mismatch("claimed_block", want.claimed_block, out_item.claimed_block);
        if (want.file_number != out_item.file_number)
          note_mismatch("file_number", want.file_number, out_item.file_number);
        if (want.status != out_item.status)
          note_mismatch("status", want.status, out_item.status);
        if (want.claimed_count != out_item.claimed_count)
          note_mismatch("claimed_count", want.claimed_count, out_item.claimed_count);
        if (want.last != out_item.last)
          note_mismatch("last", want.last, out_item.last);
        if (want.block_valid)
          blocks_granted++;
      end
      results_checked++;
    end
    if ((start && !busy) || out_valid)
      idle_cycles = 0;
    else
      idle_cycles++;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  function automatic in_item_t req(input logic mode, input int idx, input int cnt);
    in_item_t it;
    it.mode = mode;
    it.block_index = idx[7:0];
    it.block_count = cnt[5:0];
    return it;
  endfunction

  task automatic load_random(input int n);
    in_item_t it;
    int sel;
    for (int i = 0; i < n; i++) begin
      it.mode = ($urandom_range(99) < 75) ? MODE_ALLOC : MODE_MARK;
      it.block_index = ($urandom_range(99) < 80) ? 8'($urandom_range(127))
                                                 : 8'($urandom_range(255));
      sel = $urandom_range(99);
      if (sel < 70)
        it.block_count = 6'($urandom_range(3));
      else if (sel < 90)
        it.block_count = 6'($urandom_range(15));
      else
        it.block_count = 6'($urandom_range(63));
      alloc_requests.push_back(it);
    end
  endtask

  task automatic wait_drained();
    while (alloc_requests.size() > 0 || start || expected_grants.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < NUM_BLOCKS; i++)
      owner_map[i] = 8'd0;
    file_ctr = 8'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: range edges, zero count, scans past the map end, taken blocks.
    alloc_requests.push_back(req(MODE_MARK, 0, 0));
    alloc_requests.push_back(req(MODE_MARK, 127, 63));
    alloc_requests.push_back(req(MODE_MARK, 128, 0));
    alloc_requests.push_back(req(MODE_MARK, 255, 63));
    alloc_requests.push_back(req(MODE_ALLOC, 0, 0));
    alloc_requests.push_back(req(MODE_ALLOC, 200, 5));
    alloc_requests.push_back(req(MODE_ALLOC, 255, 63));
    alloc_requests.push_back(req(MODE_ALLOC, 0, 1));
    alloc_requests.push_back(req(MODE_ALLOC, 120, 10));
    alloc_requests.push_back(req(MODE_ALLOC, 0, 6));
    alloc_requests.push_back(req(MODE_ALLOC, 64, 2));
    alloc_requests.push_back(req(MODE_MARK, 65, 0));
    alloc_requests.push_back(req(MODE_ALLOC, 127, 1));
    alloc_requests.push_back(req(MODE_ALLOC, 60, 21));
    alloc_requests.push_back(req(MODE_ALLOC, 128, 0));
    wait_drained();

    sender_idle_pct = 0;
    load_random(127);
    wait_drained();
    sender_idle_pct = 57;
    load_random(127);
    wait_drained();
    sender_idle_pct = 16;
    load_random(126);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d requests sent, %0d results checked, %0d blocks granted",
             beats_in, results_checked, blocks_granted);
    $display("%0d file numbers issued, %0d requests refused for lack of file numbers",
             file_ctr, refused_requests);
    if (mismatches == 0 && expected_grants.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches, expected_grants.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
